// ===== hdl/hce_pkg.sv =====
// ----------------------------------------------------------------------------
// hce_pkg
// shared types, constants and helpers of the chunked encoder
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam logic [7:0]  CHR_CR    = 8'h0D;
    localparam logic [7:0]  CHR_LF    = 8'h0A;
    localparam logic [7:0]  CHR_ZERO  = 8'h30;
    localparam logic [15:0] MAX_RESET = 16'h8000;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef struct packed {
        logic        is_end;
        logic        hdr;
        logic        trl;
        logic [15:0] len;
        logic [7:0]  data;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

// ===== hdl/hce_front.sv =====
// ----------------------------------------------------------------------------
// hce_front
// takes input items, tracks the open chunk and builds one command per item
// ----------------------------------------------------------------------------
module hce_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_req_type,
    input  logic [7:0]    i_data_byte,
    input  logic [15:0]   i_bytes_available,
    input  logic [15:0]   i_max_chunk_size,
    input  logic          i_q_full,
    output logic          o_push,
    output hce_pkg::t_cmd o_cmd
);
    import hce_pkg::*;

    logic [15:0] r_left;
    logic [15:0] n_left;
    logic [15:0] lim;
    logic [15:0] avail;
    logic [15:0] len;
    logic [15:0] left_open;
    logic [15:0] left_after;
    logic        take;

    assign o_ready = !i_q_full;
    assign take    = i_valid && !i_q_full;

    always_comb begin
        lim        = (i_max_chunk_size == 16'd0) ? 16'd1 : i_max_chunk_size;
        avail      = (i_bytes_available == 16'd0) ? 16'd1 : i_bytes_available;
        len        = (avail > lim) ? lim : avail;
        left_open  = (r_left == 16'd0) ? len : r_left;
        left_after = left_open - 16'd1;
        o_cmd.is_end = (i_req_type == REQ_END);
        o_cmd.hdr    = (r_left == 16'd0);
        o_cmd.trl    = (left_after == 16'd0);
        o_cmd.len    = len;
        o_cmd.data   = i_data_byte;
        n_left = (i_req_type == REQ_END) ? 16'd0 : left_after;
    end

    assign o_push = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 16'd0;
        end else if (take) begin
            r_left <= n_left;
        end
    end

endmodule

// ===== hdl/hce_queue.sv =====
// ----------------------------------------------------------------------------
// hce_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module hce_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hce_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output hce_pkg::t_cmd o_cmd
);
    import hce_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/hce_back.sv =====
// ----------------------------------------------------------------------------
// hce_back
// walks each command byte by byte into the output register
// ----------------------------------------------------------------------------
module hce_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  hce_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);
    import hce_pkg::*;

    // byte positions within a command
    localparam logic [3:0] POS_HDR0    = 4'd0;
    localparam logic [3:0] POS_HDR1    = 4'd1;
    localparam logic [3:0] POS_HDR2    = 4'd2;
    localparam logic [3:0] POS_HDR3    = 4'd3;
    localparam logic [3:0] POS_HCR     = 4'd4;
    localparam logic [3:0] POS_HLF     = 4'd5;
    localparam logic [3:0] POS_BYTE    = 4'd6;
    localparam logic [3:0] POS_TCR     = 4'd7;
    localparam logic [3:0] POS_TLF     = 4'd8;
    localparam logic [3:0] POS_END_LST = 4'd4;

    logic       r_started;
    logic [3:0] r_pos;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic [3:0] cur_pos;
    logic [3:0] last_pos;
    logic       out_free;
    logic       emit;
    logic       done;
    logic [7:0] sel;

    assign out_free = !r_valid || i_ready;
    assign emit     = !i_empty && out_free;

    always_comb begin
        if (r_started) begin
            cur_pos = r_pos;
        end else if (i_cmd.is_end || i_cmd.hdr) begin
            cur_pos = POS_HDR0;
        end else begin
            cur_pos = POS_BYTE;
        end
        if (i_cmd.is_end) begin
            last_pos = POS_END_LST;
        end else if (i_cmd.trl) begin
            last_pos = POS_TLF;
        end else begin
            last_pos = POS_BYTE;
        end
        done = (cur_pos == last_pos);
    end

    always_comb begin
        if (i_cmd.is_end) begin
            case (cur_pos)
                POS_HDR0: sel = CHR_ZERO;
                POS_HDR1: sel = CHR_CR;
                POS_HDR2: sel = CHR_LF;
                POS_HDR3: sel = CHR_CR;
                default:  sel = CHR_LF;
            endcase
        end else begin
            case (cur_pos)
                POS_HDR0: sel = hex_char(i_cmd.len[15:12]);
                POS_HDR1: sel = hex_char(i_cmd.len[11:8]);
                POS_HDR2: sel = hex_char(i_cmd.len[7:4]);
                POS_HDR3: sel = hex_char(i_cmd.len[3:0]);
                POS_HCR:  sel = CHR_CR;
                POS_HLF:  sel = CHR_LF;
                POS_BYTE: sel = i_cmd.data;
                POS_TCR:  sel = CHR_CR;
                POS_TLF:  sel = CHR_LF;
                default:  sel = CHR_LF;
            endcase
        end
    end

    assign o_pop   = emit && done;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_pos     <= POS_HDR0;
            r_valid   <= 1'b0;
        end else begin
            if (emit) begin
                r_started <= !done;
                r_pos     <= cur_pos + 4'd1;
            end
            if (out_free) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= sel;
            r_last <= done;
        end
    end

endmodule

// ===== hdl/http_chunked_encoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_encoder
// wraps a byte stream in http chunked framing
//
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   tdata, tuser = req_type
// m         out  o_m_tvalid / i_m_tready   tdata = out_byte, tlast = last
// apb cfg   in   psel penable pwrite       max_chunk_size at byte address 0
//
// one result byte leaves per cycle while m is ready; an item gives 1 to 9 bytes
// a payload byte in an open chunk gives one byte, so items follow back to back
// chunk headers, trailers and the end marker are sent byte by byte in the back end
// the command queue (QDEPTH entries) absorbs those extra bytes and sets o_s_tready
// synchronous active-low reset clears the open chunk, queue and output register
// ----------------------------------------------------------------------------
module http_chunked_encoder #(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // data_byte[7:0], bytes_available[23:8]
    input  logic        i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hce_pkg::*;

    logic [15:0] r_max;
    logic        cfg_wr;
    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    t_cmd        f_cmd;
    t_cmd        q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
        end else if (cfg_wr) begin
            r_max <= pwdata[15:0];
        end
    end

    hce_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_tvalid),
        .o_ready           (o_s_tready),
        .i_req_type        (i_s_tuser),
        .i_data_byte       (i_s_tdata[7:0]),
        .i_bytes_available (i_s_tdata[23:8]),
        .i_max_chunk_size  (r_max),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_cmd             (f_cmd)
    );

    hce_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    hce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule

// ===== dv/chunk_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_frame_checker
// watches the item, result and apb channels of the chunked encoder, predicts
// the framed byte stream of every accepted item and compares it byte by byte
// ----------------------------------------------------------------------------
package hce_tb_pkg;

    localparam logic [2:0] ADDR_MAX_CHUNK = 3'd0;

endpackage

module chunk_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // data_byte[7:0], bytes_available[23:8]
    input  logic        i_s_tuser,   // req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // out_byte
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_bytes_owed
);

    import hce_pkg::*;
    import hce_tb_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_framed_byte;

    // digit v sits in byte v
    localparam logic [127:0] HEX_DIGITS = "fedcba9876543210";

    t_framed_byte owed_bytes[$];
    logic [15:0]  chunk_left;
    logic [15:0]  max_chunk;
    int           mismatches;

    task automatic predict_frame(input logic req, input logic [7:0] payload,
                                 input logic [15:0] avail);
        logic [7:0]  seq [0:8];
        logic [15:0] cap;
        logic [15:0] len;
        logic [3:0]  nib;
        int          n;
        n = 0;
        if (req == REQ_END) begin
            chunk_left = '0;
            seq[0] = CHR_ZERO;
            seq[1] = CHR_CR;
            seq[2] = CHR_LF;
            seq[3] = CHR_CR;
            seq[4] = CHR_LF;
            n = 5;
        end else begin
            if (chunk_left == '0) begin
                cap = (max_chunk == '0) ? 16'd1 : max_chunk;
                len = (avail == '0) ? 16'd1 : avail;
                if (len > cap) begin
                    len = cap;
                end
                chunk_left = len;
                for (int i = 0; i < 4; i++) begin
                    nib = len[15 - 4 * i -: 4];
                    seq[i] = HEX_DIGITS[8 * nib +: 8];
                end
                seq[4] = CHR_CR;
                seq[5] = CHR_LF;
                n = 6;
            end
            seq[n] = payload;
            n++;
            chunk_left = chunk_left - 16'd1;
            if (chunk_left == '0) begin
                seq[n] = CHR_CR;
                seq[n + 1] = CHR_LF;
                n += 2;
            end
        end
        for (int k = 0; k < n; k++) begin
            owed_bytes.push_back('{value: seq[k], last: (k == n - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        t_framed_byte want;
        if (!i_rst_n) begin
            owed_bytes.delete();
            chunk_left = '0;
            max_chunk = MAX_RESET;
            mismatches = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (owed_bytes.size() == 0) begin
                    $error("out_byte: expected none, got %02h", i_m_tdata);
                    mismatches++;
                end else begin
                    want = owed_bytes.pop_front();
                    if (i_m_tdata !== want.value) begin
                        $error("out_byte: expected %02h, got %02h", want.value, i_m_tdata);
                        mismatches++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_m_tlast);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_frame(i_s_tuser, i_s_tdata[7:0], i_s_tdata[23:8]);
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_MAX_CHUNK) begin
                max_chunk = i_pwdata[15:0];
            end
        end
        o_mismatches <= mismatches;
        o_bytes_owed <= owed_bytes.size();
    end

endmodule

// ===== dv/http_chunked_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_encoder_tb
// drives payload and end items with random gaps and output stalls, programs
// the chunk size limit between phases, and reports the verdict of the checker
// ----------------------------------------------------------------------------
module http_chunked_encoder_tb;

    import hce_pkg::*;
    import hce_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1500;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          bytes_owed;

    bit steady;
    bit long_hold;

    http_chunked_encoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    chunk_frame_checker u_frame_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_bytes_owed (bytes_owed)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = ~clk;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    task automatic send_item(input logic req, input logic [7:0] payload,
                             input logic [15:0] avail);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {avail, payload};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_delivery(input int len);
        for (int k = len; k > 0; k--) begin
            send_item(REQ_DATA, 8'($urandom), 16'(k));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (bytes_owed != 0);
    endtask

    task automatic write_max_chunk(input logic [15:0] value);
        logic [31:0] noise;
        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_CHUNK;
        pwdata  <= {noise[31:16], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int n_items);
        int sent;
        int r;
        int len;
        logic [15:0] avail;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                len = $urandom_range(1, 10);
                send_delivery(len);
                sent += len;
                if ($urandom_range(0, 3) == 0) begin
                    send_item(REQ_END, 8'($urandom), 16'($urandom));
                    sent++;
                end
            end else if (r < 88) begin
                avail = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
                send_item(REQ_DATA, 8'($urandom), avail);
                sent++;
            end else begin
                send_item(REQ_END, 8'($urandom), 16'($urandom));
                sent++;
            end
        end
        wait_drained();
    endtask

    // output side
    initial begin
        int n;
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                n = idle_span();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("http_chunked_encoder verification failed");
        $finish;
    end

    initial begin
        steady    = 1'b0;
        long_hold = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_DATA;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit, extreme bytes, clamp, end inside a chunk, end after end
        send_item(REQ_DATA, 8'h00, 16'd3);
        send_item(REQ_DATA, 8'hff, 16'd2);
        send_item(REQ_DATA, 8'ha5, 16'd1);
        send_item(REQ_END, 8'h5a, 16'hffff);
        send_item(REQ_DATA, 8'h3c, 16'd0);
        send_item(REQ_DATA, 8'h81, 16'hffff);
        send_item(REQ_DATA, 8'h7e, 16'd5);
        send_item(REQ_END, 8'hff, 16'd0);
        send_item(REQ_END, 8'h00, 16'h0001);
        send_item(REQ_DATA, 8'h0d, 16'd1);
        wait_drained();

        write_max_chunk(16'hffff);
        send_item(REQ_DATA, 8'h0a, 16'hffff);
        send_item(REQ_DATA, 8'h30, 16'd2);
        send_item(REQ_END, 8'h12, 16'h8000);
        wait_drained();

        // zero limit acts as one
        write_max_chunk(16'h0000);
        send_item(REQ_DATA, 8'h55, 16'habcd);
        send_item(REQ_DATA, 8'haa, 16'd7);
        send_item(REQ_DATA, 8'h01, 16'd0);
        wait_drained();

        // hex letters in the header
        write_max_chunk(16'h00ef);
        send_item(REQ_DATA, 8'hfe, 16'h1234);
        send_item(REQ_DATA, 8'h80, 16'h1233);
        send_item(REQ_END, 8'h7f, 16'h5555);
        send_item(REQ_DATA, 8'h40, 16'h00ef);
        send_item(REQ_END, 8'h02, 16'haaaa);
        wait_drained();

        // output held off while items keep coming
        write_max_chunk(16'h8000);
        long_hold = 1'b1;
        steady = 1'b1;
        send_delivery(12);
        steady = 1'b0;
        run_phase(10);

        write_max_chunk(16'd1);
        run_phase(8);
        run_phase(8);

        // no idling on either side
        write_max_chunk(16'd3);
        steady = 1'b1;
        run_phase(16);
        steady = 1'b0;

        write_max_chunk(16'hffff);
        run_phase(16);

        write_max_chunk(16'($urandom_range(2, 16)));
        run_phase(16);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && bytes_owed == 0) begin
            $display("http_chunked_encoder verification clean");
        end else begin
            $display("http_chunked_encoder verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hce_pkg.sv
hdl/hce_front.sv
hdl/hce_queue.sv
hdl/hce_back.sv
hdl/http_chunked_encoder.sv
dv/chunk_frame_checker.sv
dv/http_chunked_encoder_tb.sv
